// ===== hw/rtl/axis_angle_rotation_matrix_defines.svh =====
// Assertion macros used by the rotation matrix RTL (aarm_matrix).
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AARM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AARM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/aarm_pkg.sv =====
// Types, constants and tables of the axis-angle rotation matrix block.
package aarm_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;

   // Pipeline stage numbers (register outputs).
   localparam int SUM_ST     = 2;
   localparam int CORDIC_END = 1 + CORDIC_STEPS;
   localparam int SC_ST      = CORDIC_END + 1;
   localparam int SQRT_END   = SUM_ST + SQRT_STEPS;
   localparam int PREP_ST    = SQRT_END + 1;
   localparam int DIV_END    = PREP_ST + DIV_STEPS;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518853;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

   localparam logic [1:0] LAST_ROW = 2'd2;
   localparam logic [1:0] COL_T    = 2'd3;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row;
      logic [1:0]         column;
      logic signed [47:0] entry_value;
      logic               bad_axis;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [35:0] z;
      logic               neg;
   } cordic_type;

   typedef struct packed {
      logic [63:0] n;
      logic [35:0] rem;
      logic [31:0] res;
   } sqrt_type;

   typedef struct packed {
      logic [31:0]       s0;
      logic [2:0][31:0]  rem;
      logic [2:0][30:0]  lo;
      logic [2:0][30:0]  q;
   } div_type;

   typedef struct packed {
      logic              bad;
      logic [2:0]        neg;
      logic [2:0][31:0]  mag;
      logic [2:0][31:0]  p;
   } side_type;

   typedef struct packed {
      logic signed [31:0] sn;
      logic signed [31:0] cs;
   } sincos_type;

endpackage

// ===== hw/rtl/axis_angle_rotation_matrix.sv =====
// Top level: front end, CORDIC, square root and divider chains, matrix stage.
// Rotation about an axis through a point. Each accepted request yields the
// twelve upper entries of the 4x4 homogeneous transform, row by row, one per
// cycle on the rsp channel while rsp_ready is high; a zero axis yields a single
// result with bad_axis and last set. Requests enter a lockstep pipeline of 73
// stages (30 CORDIC cells, 32 square-root cells, 31 divider cells, then the
// Rodrigues product stages), so a new request can be taken every cycle while
// earlier ones are in flight and the pipeline advances. The twelve-entry output
// chain drains one entry per cycle while rsp_ready is high, one zero-axis
// result per cycle likewise, and loads the next item as its last entry is
// taken. The pipeline stalls as a whole while the output chain is busy.
module axis_angle_rotation_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  aarm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output aarm_pkg::rsp_type   rsp_data
);

   localparam int DE = aarm_pkg::DIV_END;

   logic                    adv;
   logic [DE:0]             vld_ff;
   aarm_pkg::side_type      side_in;
   aarm_pkg::side_type      side_ff [DE+1];
   logic signed [31:0]      ax [3];
   logic signed [32:0]      axw;
   logic [2:0][31:0]        mag;
   logic [31:0]             m;
   logic [4:0]              k;
   logic signed [35:0]      th0, th_in, th_ff;
   aarm_pkg::cordic_type    cinit_in, cinit_ff;
   logic [2:0][63:0]        sq_ff;
   logic [63:0]             n2_ff;
   aarm_pkg::cordic_type    cor [aarm_pkg::CORDIC_STEPS+1];
   aarm_pkg::sqrt_type      sqo [aarm_pkg::SQRT_STEPS+1];
   aarm_pkg::div_type       div_in, div_ff;
   aarm_pkg::div_type       dvo [aarm_pkg::DIV_STEPS+1];
   aarm_pkg::sincos_type    sc_in;
   aarm_pkg::sincos_type    sc_ff [aarm_pkg::SC_ST:DE];
   logic signed [33:0]      xn, yn;
   logic [61:0]             num;

   assign req_ready = adv;

   // front end: magnitudes, normalizing shift, angle wrap
   always_comb begin
      ax[0] = req_data.axis_x;
      ax[1] = req_data.axis_y;
      ax[2] = req_data.axis_z;
      for (int i = 0; i < 3; i++) begin
         axw    = 33'(ax[i]);
         mag[i] = axw[32] ? 32'(-axw) : 32'(axw);
      end
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      k = '0;
      if (!m[31]) begin
         for (int b = 0; b < 31; b++)
            if (m[b]) k = 5'(30 - b);
      end
      side_in.bad = (m == '0);
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = ax[i][31];
         side_in.mag[i] = mag[i] << k;
      end
      side_in.p[0] = req_data.center_x;
      side_in.p[1] = req_data.center_y;
      side_in.p[2] = req_data.center_z;

      th0 = 36'($signed({req_data.angle, 2'b00}));
      if (th0 > aarm_pkg::PI_Q30)       th_in = th0 - aarm_pkg::TWO_PI_Q30;
      else if (th0 < -aarm_pkg::PI_Q30) th_in = th0 + aarm_pkg::TWO_PI_Q30;
      else                              th_in = th0;
   end

   // fold into the right half plane
   always_comb begin
      cinit_in.x   = aarm_pkg::CORDIC_GAIN;
      cinit_in.y   = '0;
      cinit_in.z   = th_ff;
      cinit_in.neg = 1'b0;
      if (th_ff > aarm_pkg::HALF_PI_Q30) begin
         cinit_in.z   = th_ff - aarm_pkg::PI_Q30;
         cinit_in.neg = 1'b1;
      end else if (th_ff < -aarm_pkg::HALF_PI_Q30) begin
         cinit_in.z   = th_ff + aarm_pkg::PI_Q30;
         cinit_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[DE-1:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= DE; s++) side_ff[s] <= side_ff[s-1];
         th_ff    <= th_in;
         cinit_ff <= cinit_in;
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= 64'(side_ff[0].mag[i]) * 64'(side_ff[0].mag[i]);
         n2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         sc_ff[aarm_pkg::SC_ST] <= sc_in;
         for (int s = aarm_pkg::SC_ST + 1; s <= DE; s++) sc_ff[s] <= sc_ff[s-1];
         div_ff <= div_in;
      end
   end

   assign cor[0] = cinit_ff;
   for (genvar i = 0; i < aarm_pkg::CORDIC_STEPS; i++) begin : g_cordic
      aarm_cordic_cell u_cell (
         .clock     (clock),
         .en        (adv),
         .shift     (5'(i)),
         .atan_val  (aarm_pkg::ATAN_TAB[i]),
         .from_prev (cor[i]),
         .to_next   (cor[i+1])
      );
   end

   // undo the fold and clamp to unit range
   always_comb begin
      xn = cor[aarm_pkg::CORDIC_STEPS].neg ? -cor[aarm_pkg::CORDIC_STEPS].x
                                           : cor[aarm_pkg::CORDIC_STEPS].x;
      yn = cor[aarm_pkg::CORDIC_STEPS].neg ? -cor[aarm_pkg::CORDIC_STEPS].y
                                           : cor[aarm_pkg::CORDIC_STEPS].y;
      if (xn > 34'(aarm_pkg::ONE_Q30))       sc_in.cs = aarm_pkg::ONE_Q30;
      else if (xn < -34'(aarm_pkg::ONE_Q30)) sc_in.cs = -aarm_pkg::ONE_Q30;
      else                                   sc_in.cs = 32'(xn);
      if (yn > 34'(aarm_pkg::ONE_Q30))       sc_in.sn = aarm_pkg::ONE_Q30;
      else if (yn < -34'(aarm_pkg::ONE_Q30)) sc_in.sn = -aarm_pkg::ONE_Q30;
      else                                   sc_in.sn = 32'(yn);
   end

   always_comb begin
      sqo[0].n   = n2_ff;
      sqo[0].rem = '0;
      sqo[0].res = '0;
   end

   for (genvar i = 0; i < aarm_pkg::SQRT_STEPS; i++) begin : g_sqrt
      aarm_sqrt_cell u_cell (
         .clock     (clock),
         .en        (adv),
         .from_prev (sqo[i]),
         .to_next   (sqo[i+1])
      );
   end

   // numerator with half-divisor rounding; top bits seed the remainder
   always_comb begin
      div_in.s0 = sqo[aarm_pkg::SQRT_STEPS].res;
      num = '0;
      for (int i = 0; i < 3; i++) begin
         num = {side_ff[aarm_pkg::SQRT_END].mag[i], 30'b0}
               + 62'(sqo[aarm_pkg::SQRT_STEPS].res >> 1);
         div_in.rem[i] = {1'b0, num[61:31]};
         div_in.lo[i]  = num[30:0];
         div_in.q[i]   = '0;
      end
   end

   assign dvo[0] = div_ff;
   for (genvar i = 0; i < aarm_pkg::DIV_STEPS; i++) begin : g_div
      aarm_div_cell u_cell (
         .clock     (clock),
         .en        (adv),
         .from_prev (dvo[i]),
         .to_next   (dvo[i+1])
      );
   end

   aarm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[DE]),
      .in_q      (dvo[aarm_pkg::DIV_STEPS].q),
      .in_side   (side_ff[DE]),
      .in_sc     (sc_ff[DE]),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/aarm_cordic_cell.sv =====
// One CORDIC rotation step with its stage register.
module aarm_cordic_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic [4:0]             shift,
   input  logic [31:0]            atan_val,
   input  aarm_pkg::cordic_type   from_prev,
   output aarm_pkg::cordic_type   to_next
);

   aarm_pkg::cordic_type step_in, step_ff;
   logic signed [33:0] xs, ys;
   logic signed [35:0] av;

   always_comb begin
      xs = from_prev.x >>> shift;
      ys = from_prev.y >>> shift;
      av = $signed({4'b0000, atan_val});
      step_in = from_prev;
      if (!from_prev.z[35]) begin
         step_in.x = from_prev.x - ys;
         step_in.y = from_prev.y + xs;
         step_in.z = from_prev.z - av;
      end else begin
         step_in.x = from_prev.x + ys;
         step_in.y = from_prev.y - xs;
         step_in.z = from_prev.z + av;
      end
   end

   always_ff @(posedge clock) begin
      if (en) step_ff <= step_in;
   end

   assign to_next = step_ff;

endmodule

// ===== hw/rtl/aarm_sqrt_cell.sv =====
// One result bit of the integer square root with its stage register.
module aarm_sqrt_cell (
   input  logic                 clock,
   input  logic                 en,
   input  aarm_pkg::sqrt_type   from_prev,
   output aarm_pkg::sqrt_type   to_next
);

   aarm_pkg::sqrt_type step_in, step_ff;
   logic [35:0] rem2, trial;

   always_comb begin
      rem2  = {from_prev.rem[33:0], from_prev.n[63:62]};
      trial = {2'b00, from_prev.res, 2'b01};
      step_in.n = {from_prev.n[61:0], 2'b00};
      if (rem2 >= trial) begin
         step_in.rem = rem2 - trial;
         step_in.res = {from_prev.res[30:0], 1'b1};
      end else begin
         step_in.rem = rem2;
         step_in.res = {from_prev.res[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) step_ff <= step_in;
   end

   assign to_next = step_ff;

endmodule

// ===== hw/rtl/aarm_div_cell.sv =====
// One quotient bit of the three axis divisions with its stage register.
module aarm_div_cell (
   input  logic                clock,
   input  logic                en,
   input  aarm_pkg::div_type   from_prev,
   output aarm_pkg::div_type   to_next
);

   aarm_pkg::div_type step_in, step_ff;
   logic [2:0][32:0] r2;

   always_comb begin
      step_in.s0 = from_prev.s0;
      for (int i = 0; i < 3; i++) begin
         r2[i] = {from_prev.rem[i], from_prev.lo[i][30]};
         step_in.lo[i] = {from_prev.lo[i][29:0], 1'b0};
         if (r2[i] >= {1'b0, from_prev.s0}) begin
            step_in.rem[i] = 32'(r2[i] - {1'b0, from_prev.s0});
            step_in.q[i]   = {from_prev.q[i][29:0], 1'b1};
         end else begin
            step_in.rem[i] = r2[i][31:0];
            step_in.q[i]   = {from_prev.q[i][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) step_ff <= step_in;
   end

   assign to_next = step_ff;

endmodule

// ===== hw/rtl/aarm_matrix.sv =====
// Rodrigues products, translation and the twelve-entry output shift chain.
`include "axis_angle_rotation_matrix_defines.svh"

module aarm_matrix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2:0][30:0]       in_q,
   input  aarm_pkg::side_type     in_side,
   input  aarm_pkg::sincos_type   in_sc,
   output logic                   adv,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output aarm_pkg::rsp_type      rsp_data
);

   function automatic logic signed [34:0] mulq(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
      logic signed [67:0] pr;
      pr = 68'(a) * 68'(b) + 68'sd536870912;
      return 35'(pr >>> 30);
   endfunction

   localparam int F = 5;

   logic [F:0] vld_ff, vld_in;

   // stage a
   logic signed [31:0] u_a_ff [3];
   logic signed [32:0] t_a_ff;
   logic signed [31:0] sn_a_ff, cs_a_ff;
   logic [2:0][31:0]   p_a_ff;
   logic               bad_a_ff;
   // stage b
   logic signed [32:0] tu_b_ff [3];
   logic signed [31:0] su_b_ff [3];
   logic signed [31:0] u_b_ff [3];
   logic signed [31:0] cs_b_ff;
   logic [2:0][31:0]   p_b_ff;
   logic               bad_b_ff;
   // stage c
   logic signed [32:0] pr_c_ff [3][3];
   logic signed [31:0] su_c_ff [3];
   logic signed [31:0] cs_c_ff;
   logic [2:0][31:0]   p_c_ff;
   logic               bad_c_ff;
   // stage d
   logic signed [33:0] r_d_ff [3][3];
   logic [2:0][31:0]   p_d_ff;
   logic               bad_d_ff;
   // stage e
   logic signed [49:0] rp_e_ff [3][3];
   logic signed [33:0] r_e_ff [3][3];
   logic [2:0][31:0]   p_e_ff;
   logic               bad_e_ff;
   // stage f
   logic signed [47:0] tr_f_ff [3];
   logic signed [33:0] r_f_ff [3][3];
   logic               bad_f_ff;

   logic signed [31:0] u_in [3];
   logic [30:0]        qc;
   logic signed [51:0] tr_sum [3];
   logic signed [47:0] tr_in [3];

   // output shift chain
   logic signed [47:0] val_ff [12];
   logic signed [47:0] val_in [12];
   logic [1:0]         row_ff, row_in, col_ff, col_in;
   logic               bad_ff, bad_in, ser_v_ff, ser_v_in;
   logic               last, load;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc = (in_q[i] > 31'(aarm_pkg::ONE_Q30)) ? 31'(aarm_pkg::ONE_Q30) : in_q[i];
         u_in[i] = in_side.neg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tr_sum[i] = 52'($signed(p_e_ff[i])) * 52'sd16384
                     - 52'(rp_e_ff[i][0]) - 52'(rp_e_ff[i][1]) - 52'(rp_e_ff[i][2]);
         if (tr_sum[i] > 52'sd140737488355327)       tr_in[i] = 48'sh7FFFFFFFFFFF;
         else if (tr_sum[i] < -52'sd140737488355328) tr_in[i] = 48'sh800000000000;
         else                                        tr_in[i] = 48'(tr_sum[i]);
      end
   end

   assign last   = bad_ff || (row_ff == aarm_pkg::LAST_ROW && col_ff == aarm_pkg::COL_T);
   assign adv    = !vld_ff[F] || !ser_v_ff || (rsp_ready && last);
   assign load   = vld_ff[F] && adv;
   assign vld_in = {vld_ff[F-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset)    vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) u_a_ff[i] <= u_in[i];
         t_a_ff   <= 33'sd1073741824 - 33'(in_sc.cs);
         sn_a_ff  <= in_sc.sn;
         cs_a_ff  <= in_sc.cs;
         p_a_ff   <= in_side.p;
         bad_a_ff <= in_side.bad;

         for (int i = 0; i < 3; i++) begin
            tu_b_ff[i] <= 33'(mulq(34'(t_a_ff), 34'(u_a_ff[i])));
            su_b_ff[i] <= 32'(mulq(34'(sn_a_ff), 34'(u_a_ff[i])));
            u_b_ff[i]  <= u_a_ff[i];
         end
         cs_b_ff  <= cs_a_ff;
         p_b_ff   <= p_a_ff;
         bad_b_ff <= bad_a_ff;

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               pr_c_ff[i][j] <= 33'(mulq(34'(tu_b_ff[i]), 34'(u_b_ff[j])));
            su_c_ff[i] <= su_b_ff[i];
         end
         cs_c_ff  <= cs_b_ff;
         p_c_ff   <= p_b_ff;
         bad_c_ff <= bad_b_ff;

         for (int i = 0; i < 3; i++)
            r_d_ff[i][i] <= 34'(pr_c_ff[i][i]) + 34'(cs_c_ff);
         r_d_ff[0][1] <= 34'(pr_c_ff[0][1]) - 34'(su_c_ff[2]);
         r_d_ff[1][0] <= 34'(pr_c_ff[1][0]) + 34'(su_c_ff[2]);
         r_d_ff[0][2] <= 34'(pr_c_ff[0][2]) + 34'(su_c_ff[1]);
         r_d_ff[2][0] <= 34'(pr_c_ff[2][0]) - 34'(su_c_ff[1]);
         r_d_ff[1][2] <= 34'(pr_c_ff[1][2]) - 34'(su_c_ff[0]);
         r_d_ff[2][1] <= 34'(pr_c_ff[2][1]) + 34'(su_c_ff[0]);
         p_d_ff   <= p_c_ff;
         bad_d_ff <= bad_c_ff;

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rp_e_ff[i][j] <= 50'((66'(r_d_ff[i][j]) * 66'($signed(p_d_ff[j]))
                                     + 66'sd32768) >>> 16);
               r_e_ff[i][j]  <= r_d_ff[i][j];
            end
         end
         p_e_ff   <= p_d_ff;
         bad_e_ff <= bad_d_ff;

         for (int i = 0; i < 3; i++) begin
            tr_f_ff[i] <= tr_in[i];
            for (int j = 0; j < 3; j++) r_f_ff[i][j] <= r_e_ff[i][j];
         end
         bad_f_ff <= bad_e_ff;
      end
   end

   always_comb begin
      val_in   = val_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      bad_in   = bad_ff;
      ser_v_in = ser_v_ff;
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) val_in[i*4+j] = 48'(r_f_ff[i][j]);
            val_in[i*4+3] = tr_f_ff[i];
         end
         row_in   = '0;
         col_in   = '0;
         bad_in   = bad_f_ff;
         ser_v_in = 1'b1;
      end else if (ser_v_ff && rsp_ready) begin
         if (last) begin
            ser_v_in = 1'b0;
         end else begin
            // advance the chain by one entry
            for (int k = 0; k < 11; k++) val_in[k] = val_ff[k+1];
            if (col_ff == aarm_pkg::COL_T) begin
               col_in = '0;
               row_in = row_ff + 2'd1;
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ser_v_ff <= 1'b0;
      else       ser_v_ff <= ser_v_in;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      row_ff <= row_in;
      col_ff <= col_in;
      bad_ff <= bad_in;
   end

   assign rsp_valid            = ser_v_ff;
   assign rsp_data.row         = bad_ff ? 2'd0 : row_ff;
   assign rsp_data.column      = bad_ff ? 2'd0 : col_ff;
   assign rsp_data.entry_value = bad_ff ? 48'sd0 : val_ff[0];
   assign rsp_data.bad_axis    = bad_ff;
   assign rsp_data.last        = last;

   `AARM_ASSERT_NOW(a_bad_is_last, clock, reset, rsp_valid && rsp_data.bad_axis, rsp_data.last, "bad axis result not marked last")
   `AARM_ASSERT_NEXT(a_row_wrap, clock, reset, rsp_valid && rsp_ready && rsp_data.column == aarm_pkg::COL_T && !rsp_data.last, rsp_valid && rsp_data.column == 2'd0 && rsp_data.row == 2'($past(rsp_data.row) + 2'd1), "row did not advance after translation entry")
   `AARM_ASSERT_NEXT(a_no_extra, clock, reset, rsp_valid && rsp_ready && rsp_data.last && !vld_ff[F], !rsp_valid, "result shown with no item behind it")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the axis-angle rotation matrix block.
`timescale 1ns / 100ps

module testbench;

   localparam longint ONE      = 64'sd1 << 30;
   localparam longint PI       = 64'sd3373259426;
   localparam longint TWO_PI   = 64'sd6746518853;
   localparam longint HALF_PI  = 64'sd1686629713;
   localparam longint GAIN     = 64'sd652032874;
   localparam longint SAT_MAX  = (64'sd1 <<< 47) - 1;
   localparam longint SAT_MIN  = -(64'sd1 <<< 47);
   localparam int     DRAIN    = 120;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   aarm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   aarm_pkg::rsp_type rsp_data;

   aarm_pkg::req_type pending_req[$];
   aarm_pkg::rsp_type matrix_entries[$];
   bit                req_fire;
   int                n_in, n_out, n_bad_axis, n_errors;

   axis_angle_rotation_matrix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n -= res + bt;
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   task automatic sine_cosine(input longint theta, output longint sn, output longint cs);
      longint x, y, z, nx;
      bit     flip;
      x = GAIN;
      y = 0;
      flip = 0;
      if (theta > PI) theta -= TWO_PI;
      else if (theta < -PI) theta += TWO_PI;
      if (theta > HALF_PI) begin
         theta -= PI;
         flip = 1;
      end else if (theta < -HALF_PI) begin
         theta += PI;
         flip = 1;
      end
      z = theta;
      for (int i = 0; i < aarm_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= longint'(aarm_pkg::ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += longint'(aarm_pkg::ATAN_TAB[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cs = clamp(x, -ONE, ONE);
      sn = clamp(y, -ONE, ONE);
   endtask

   // Queue the entries that one request must produce.
   task automatic predict_matrix(input aarm_pkg::req_type rq);
      longint ax[3], u[3], p[3], rot[3][3];
      longint sn, cs, t, m, tu, tr;
      longint unsigned n2, s0, mag, q;
      int      k;
      aarm_pkg::rsp_type e;
      ax[0] = rq.axis_x;   ax[1] = rq.axis_y;   ax[2] = rq.axis_z;
      p[0]  = rq.center_x; p[1]  = rq.center_y; p[2]  = rq.center_z;
      m = 0;
      k = 0;
      n2 = 0;
      for (int i = 0; i < 3; i++)
         if ((ax[i] < 0 ? -ax[i] : ax[i]) > m) m = ax[i] < 0 ? -ax[i] : ax[i];
      if (m == 0) begin
         e = '0;
         e.bad_axis = 1'b1;
         e.last = 1'b1;
         matrix_entries.push_back(e);
         n_bad_axis++;
         return;
      end
      while (m < ONE) begin
         m <<= 1;
         k++;
      end
      for (int i = 0; i < 3; i++) begin
         ax[i] = ax[i] * (64'sd1 <<< k);
         mag = ax[i] < 0 ? -ax[i] : ax[i];
         n2 += mag * mag;
      end
      s0 = int_sqrt(n2);
      for (int i = 0; i < 3; i++) begin
         mag = ax[i] < 0 ? -ax[i] : ax[i];
         q = ((mag << 30) + (s0 >> 1)) / s0;
         if (q > 64'd1 << 30) q = 64'd1 << 30;
         u[i] = ax[i] < 0 ? -longint'(q) : longint'(q);
      end
      sine_cosine(longint'(rq.angle) * 4, sn, cs);
      t = ONE - cs;
      for (int i = 0; i < 3; i++) begin
         tu = mul_q30(t, u[i]);
         for (int j = 0; j < 3; j++) rot[i][j] = mul_q30(tu, u[j]);
         rot[i][i] += cs;
      end
      rot[0][1] -= mul_q30(sn, u[2]);
      rot[1][0] += mul_q30(sn, u[2]);
      rot[0][2] += mul_q30(sn, u[1]);
      rot[2][0] -= mul_q30(sn, u[1]);
      rot[1][2] -= mul_q30(sn, u[0]);
      rot[2][1] += mul_q30(sn, u[0]);
      for (int i = 0; i < 3; i++) begin
         tr = p[i] * 16384;
         for (int j = 0; j < 3; j++) tr -= (rot[i][j] * p[j] + (64'sd1 <<< 15)) >>> 16;
         tr = clamp(tr, SAT_MIN, SAT_MAX);
         for (int j = 0; j < 4; j++) begin
            e.row         = 2'(i);
            e.column      = 2'(j);
            e.entry_value = 48'(j < 3 ? rot[i][j] : tr);
            e.bad_axis    = 1'b0;
            e.last        = (i == 2 && j == 3);
            matrix_entries.push_back(e);
         end
      end
   endtask

   function automatic aarm_pkg::req_type make_req(logic [31:0] ang, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z,
                                                  logic [31:0] cx, logic [31:0] cy,
                                                  logic [31:0] cz);
      aarm_pkg::req_type r;
      r.angle = ang; r.axis_x = x; r.axis_y = y; r.axis_z = z;
      r.center_x = cx; r.center_y = cy; r.center_z = cz;
      return r;
   endfunction

   function automatic logic [31:0] rand_axis();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(7) - 3;
         2:       return $signed($urandom_range(2000)) - 1000;
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   // Quiet window: no idling on either side.
   function automatic bit quiet();
      return n_in >= 100 && n_in < 160;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      // zero axis, coordinate axes, extremes of every field, wrap and fold cases
      pending_req.push_back(make_req(32'h1000_0000, 0, 0, 0, 0, 0, 0));
      pending_req.push_back(make_req(32'h1000_0000, 1, 0, 0, 32'h1_0000, 32'h2_0000, 0));
      pending_req.push_back(make_req(32'h1000_0000, 0, 1, 0, 32'h1_0000, 32'h2_0000, 0));
      pending_req.push_back(make_req(32'h1000_0000, 0, 0, -1, 32'h1_0000, 32'h2_0000, 0));
      pending_req.push_back(make_req(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
      pending_req.push_back(make_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF));
      pending_req.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000));
      pending_req.push_back(make_req(0, 3, 4, 12, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678));
      pending_req.push_back(make_req(32'h3243_F6A9, 1, 1, 1, 32'h8000_0000,
                                     32'h8000_0000, 32'h7FFF_FFFF));
      pending_req.push_back(make_req(32'hCDBC_0957, -1, 2, -3, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h7FFF_FFFF));
      pending_req.push_back(make_req(32'h1921_FB54, 0, 0, 5, 32'h10_0000, 0, 0));
      pending_req.push_back(make_req(32'h1921_FB55, 7, 0, 0, 0, 32'h10_0000, 0));
      pending_req.push_back(make_req(32'h6487_ED51, 0, -9, 0, 0, 0, 32'h10_0000));
      pending_req.push_back(make_req(32'h9B78_12AF, 5, 5, 0, 32'hFFFF_0000, 1, -1));
      pending_req.push_back(make_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                                     -1, 0, 1));
      pending_req.push_back(make_req(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      for (int i = 0; i < 250; i++) begin
         if ($urandom_range(19) == 0)
            pending_req.push_back(make_req($urandom, 0, 0, 0, $urandom, $urandom, $urandom));
         else
            pending_req.push_back(make_req($urandom, rand_axis(), rand_axis(), rand_axis(),
                                           $urandom, $urandom, $urandom));
      end
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 0;
   end

   // Request driver: present a new item only once the previous one transferred.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_req.size() > 0 && (quiet() || $urandom_range(99) >= 32)) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
         rsp_ready <= quiet() || $urandom_range(99) >= 32;
      end
   end

   // Monitor: predict on each request transfer, check each result transfer.
   always @(posedge clock) begin
      aarm_pkg::rsp_type e;
      req_fire = req_valid && req_ready;
      if (!reset) begin
         if (req_fire) begin
            predict_matrix(req_data);
            n_in++;
         end
         if (rsp_valid && rsp_ready) begin
            n_out++;
            if (matrix_entries.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               n_errors++;
            end else begin
               e = matrix_entries.pop_front();
               if (rsp_data.row !== e.row || rsp_data.column !== e.column ||
                   rsp_data.entry_value !== e.entry_value ||
                   rsp_data.bad_axis !== e.bad_axis || rsp_data.last !== e.last) begin
                  $display("%0t: mismatch expected row %0d col %0d value %0d bad %0b last %0b",
                           $time, e.row, e.column, e.entry_value, e.bad_axis, e.last);
                  $display("%0t:          actual row %0d col %0d value %0d bad %0b last %0b",
                           $time, rsp_data.row, rsp_data.column, rsp_data.entry_value,
                           rsp_data.bad_axis, rsp_data.last);
                  n_errors++;
               end
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      do @(posedge clock);
      while (pending_req.size() > 0 || req_valid || matrix_entries.size() > 0);
      repeat (DRAIN) @(posedge clock);
      if (matrix_entries.size() > 0) begin
         $display("%0t: %0d expected results never arrived", $time, matrix_entries.size());
         n_errors++;
      end
      $display("Sent %0d requests (%0d with a zero axis), checked %0d matrix entries.",
               n_in, n_bad_axis, n_out);
      if (n_errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #1000000;
      $display("%0t: timeout", $time);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
